### design/fabr_pkg.sv
`default_nettype none
package fabr_pkg;

  // frame buffer limit and derived frame counter width
  localparam int BUFFER_SIZE = 64;
  localparam int CNT_W = $clog2(BUFFER_SIZE + 1);

  // response descriptor queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  // register indexes
  localparam logic [2:0] REG_START = 3'd0;
  localparam logic [2:0] REG_END   = 3'd1;
  localparam logic [2:0] REG_SEP   = 3'd2;
  localparam logic [2:0] REG_ACK   = 3'd3;
  localparam logic [2:0] REG_NAK   = 3'd4;

  // response kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_NAK   = 2'd1;
  localparam logic [1:0] KIND_OK    = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_O    = 8'h4f;
  localparam logic [7:0] CHAR_K    = 8'h4b;
  localparam logic [7:0] CNT_MAX   = 8'd255;

  // byte positions in a response
  localparam logic [3:0] LAST_SHORT = 4'd8;
  localparam logic [3:0] LAST_LONG  = 4'd10;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] separator_code;
    logic [7:0] ack_code;
    logic [7:0] nak_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] seq;
    logic [7:0] frame_errors;
    logic [7:0] overlong_errors;
  } desc_t;

endpackage
`default_nettype wire

### design/fabr_front.sv
`default_nettype none
module fabr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fabr_pkg::cfg_t cfg,
  input  wire logic          take,
  input  wire logic [7:0]    rx_byte,
  output fabr_pkg::desc_t    desc,
  output logic               desc_push
);
  import fabr_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       seq_byte, seq_byte_next;
  logic [7:0]       hist [0:4];
  logic             expected_seq, expected_seq_next;
  logic [1:0]       last_kind, last_kind_next;
  logic [7:0]       last_seq, last_seq_next;
  logic [7:0]       frame_errors, frame_errors_next;
  logic [7:0]       overlong_errors, overlong_errors_next;

  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       seq_eff;
  logic [7:0]       exp_char;
  logic             in_frame, is_end, bad, shift;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  always_comb begin
    cnt_inc  = byte_count + 1'b1;
    in_frame = (byte_count != '0) || (rx_byte == cfg.start_code);
    is_end   = rx_byte == cfg.end_code;
    shift    = take && in_frame;
    if (byte_count == '0) begin
      seq_eff = 8'd0;
    end else if (byte_count == CNT_W'(1)) begin
      seq_eff = rx_byte;
    end else begin
      seq_eff = seq_byte;
    end
    exp_char = {7'h18, expected_seq};
    // window holds the five bytes before the end code
    bad = (cnt_inc < CNT_W'(8)) ||
          (seq_eff != CHAR_ZERO && seq_eff != CHAR_ONE) ||
          (hist[0] != cfg.separator_code) ||
          !is_hex(hist[1]) || !is_hex(hist[2]) ||
          !is_hex(hist[3]) || !is_hex(hist[4]);

    byte_count_next      = byte_count;
    seq_byte_next        = seq_byte;
    expected_seq_next    = expected_seq;
    last_kind_next       = last_kind;
    last_seq_next        = last_seq;
    frame_errors_next    = frame_errors;
    overlong_errors_next = overlong_errors;
    desc_push            = 1'b0;
    desc.kind            = last_kind;
    desc.seq             = last_seq;

    if (shift) begin
      seq_byte_next = seq_eff;
      byte_count_next = cnt_inc;
      if (is_end) begin
        byte_count_next = '0;
        desc_push = 1'b1;
        if (bad) begin
          if (frame_errors != CNT_MAX) frame_errors_next = frame_errors + 8'd1;
          last_kind_next = KIND_NAK;
          last_seq_next  = seq_eff;
          desc.kind      = KIND_NAK;
          desc.seq       = seq_eff;
        end else if (seq_eff != exp_char && last_kind != KIND_NONE) begin
          // repeat of the previous response, state untouched
          desc.kind = last_kind;
          desc.seq  = last_seq;
        end else if (seq_eff != exp_char) begin
          last_kind_next = KIND_OTHER;
          last_seq_next  = {7'h18, ~expected_seq};
          desc.kind      = KIND_OTHER;
          desc.seq       = {7'h18, ~expected_seq};
        end else begin
          last_kind_next    = KIND_OK;
          last_seq_next     = seq_eff;
          expected_seq_next = ~expected_seq;
          desc.kind         = KIND_OK;
          desc.seq          = seq_eff;
        end
      end else if (cnt_inc >= CNT_W'(BUFFER_SIZE)) begin
        byte_count_next = '0;
        if (overlong_errors != CNT_MAX) overlong_errors_next = overlong_errors + 8'd1;
      end
    end
    desc.frame_errors    = frame_errors_next;
    desc.overlong_errors = overlong_errors;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      seq_byte        <= '0;
      expected_seq    <= 1'b0;
      last_kind       <= KIND_NONE;
      last_seq        <= '0;
      frame_errors    <= '0;
      overlong_errors <= '0;
      for (int i = 0; i < 5; i++) hist[i] <= '0;
    end else begin
      byte_count      <= byte_count_next;
      seq_byte        <= seq_byte_next;
      expected_seq    <= expected_seq_next;
      last_kind       <= last_kind_next;
      last_seq        <= last_seq_next;
      frame_errors    <= frame_errors_next;
      overlong_errors <= overlong_errors_next;
      if (shift) begin
        for (int i = 0; i < 4; i++) hist[i] <= hist[i+1];
        hist[4] <= rx_byte;
      end
    end
  end

endmodule
`default_nettype wire

### design/fabr_queue.sv
`default_nettype none
module fabr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fabr_pkg::desc_t wdata,
  input  wire logic           pop,
  output fabr_pkg::desc_t     rdata,
  output logic                full,
  output logic                empty
);
  import fabr_pkg::*;

  desc_t        mem [0:QDEPTH-1];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           do_push, do_pop;

  assign full    = count == (QAW+1)'(QDEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[QAW-1:0])
    else $error("queue pointers disagree with count");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(full && empty))
    else $error("queue full and empty at once");

endmodule
`default_nettype wire

### design/fabr_back.sv
`default_nettype none
module fabr_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire fabr_pkg::cfg_t  cfg,
  input  wire fabr_pkg::desc_t q_data,
  input  wire logic            q_empty,
  output logic                 q_pop,
  input  wire logic            pop,
  output logic                 empty,
  output logic [7:0]           tx_byte,
  output logic                 tx_last,
  output logic [7:0]           frame_error_count,
  output logic [7:0]           too_long_count
);
  import fabr_pkg::*;

  logic       busy;
  logic [3:0] idx;
  desc_t      cur;
  logic       advance;

  assign empty   = !busy;
  assign tx_last = (cur.kind == KIND_OK) ? (idx == LAST_LONG) : (idx == LAST_SHORT);
  assign advance = !busy || (pop && tx_last);
  assign q_pop   = advance && !q_empty;
  assign frame_error_count = cur.frame_errors;
  assign too_long_count    = cur.overlong_errors;

  always_comb begin
    tx_byte = CHAR_ZERO;
    if (cur.kind == KIND_OK) begin
      case (idx)
        4'd0:    tx_byte = cfg.start_code;
        4'd1:    tx_byte = cur.seq;
        4'd2:    tx_byte = cfg.ack_code;
        4'd3:    tx_byte = CHAR_O;
        4'd4:    tx_byte = CHAR_K;
        4'd5:    tx_byte = cfg.separator_code;
        4'd10:   tx_byte = cfg.end_code;
        default: tx_byte = CHAR_ZERO;
      endcase
    end else begin
      case (idx)
        4'd0:    tx_byte = cfg.start_code;
        4'd1:    tx_byte = cur.seq;
        4'd2:    tx_byte = (cur.kind == KIND_NAK) ? cfg.nak_code : cfg.ack_code;
        4'd3:    tx_byte = cfg.separator_code;
        4'd8:    tx_byte = cfg.end_code;
        default: tx_byte = CHAR_ZERO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (advance) begin
      busy <= !q_empty;
      idx  <= '0;
    end else if (pop) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  a_idx_hold: assert property (@(posedge clk) disable iff (rst)
    busy && !pop |=> $stable(idx) && busy)
    else $error("response word changed while stalled");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= LAST_LONG)
    else $error("response index past end");

  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    busy |-> cur.kind != KIND_NONE)
    else $error("response without kind");

endmodule
`default_nettype wire

### design/framed_alternating_bit_responder_top.sv
`default_nettype none
// channel   handshake          payload
// input     push / full        rx_byte
// result    empty / pop        tx_byte, tx_last, frame_error_count, too_long_count
// config    cfg_write          cfg_index, cfg_data
//
// One input word per cycle unless full; frame state updates in the same cycle it is taken.
// A closing byte queues a response descriptor (4 deep); the back end sends one
// response word per cycle while pop is high, 9 or 11 words per response, back to back.
// full rises only when the descriptor queue is full; result stalls never block
// input until then. Reset (rst, synchronous) restores code registers and clears
// frame state, counters and the queue at once.
module framed_alternating_bit_responder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      tx_byte,
  output logic            tx_last,
  output logic [7:0]      frame_error_count,
  output logic [7:0]      too_long_count,
  input  wire logic       cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import fabr_pkg::*;

  cfg_t  cfg;
  desc_t f_desc, q_data;
  logic  q_push, q_pop, q_full, q_empty;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code     <= 8'd2;
      cfg.end_code       <= 8'd3;
      cfg.separator_code <= 8'd29;
      cfg.ack_code       <= 8'd6;
      cfg.nak_code       <= 8'd21;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_START: cfg.start_code     <= cfg_data;
        REG_END:   cfg.end_code       <= cfg_data;
        REG_SEP:   cfg.separator_code <= cfg_data;
        REG_ACK:   cfg.ack_code       <= cfg_data;
        REG_NAK:   cfg.nak_code       <= cfg_data;
        default:   ;
      endcase
    end
  end

  assign full = q_full;
  assign take = push && !q_full;

  fabr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .take      (take),
    .rx_byte   (rx_byte),
    .desc      (f_desc),
    .desc_push (q_push)
  );

  fabr_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (f_desc),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  fabr_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_data            (q_data),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .pop               (pop),
    .empty             (empty),
    .tx_byte           (tx_byte),
    .tx_last           (tx_last),
    .frame_error_count (frame_error_count),
    .too_long_count    (too_long_count)
  );

endmodule
`default_nettype wire
